// ===== rtl/core/ethernet_ipv4_icmp_frame_validator_assert.svh =====
// assertion macros shared by the frame validator modules
`ifndef ETHERNET_IPV4_ICMP_FRAME_VALIDATOR_ASSERT_SVH
`define ETHERNET_IPV4_ICMP_FRAME_VALIDATOR_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define EIV_ASSERT_HOLDS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define EIV_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/eiv_pkg.sv =====
// shared constants, types and functions of the frame validator
`default_nettype none

package eiv_pkg;

  localparam int MaxFrameBytesDef = 2048;

  localparam int ByteW     = 8;
  localparam int VerdictW  = 4;
  localparam int FrameLenW = 12;
  localparam int WordW     = 16;

  localparam int PosTypeHi    = 12;
  localparam int PosTypeLo    = 13;
  localparam int PosProto     = 23;
  localparam int EthHdrBytes  = 14;
  localparam int IpEndBytes   = 34;
  localparam int IcmpMinBytes = 38;
  localparam int ArpMinBytes  = 42;

  localparam logic [WordW-1:0] TypeIpv4  = 16'h0800;
  localparam logic [WordW-1:0] TypeArp   = 16'h0806;
  localparam logic [ByteW-1:0] ProtoIcmp = 8'h01;
  localparam logic [WordW-1:0] SumOk     = 16'hFFFF;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_OTHER     = 4'd0,
    VERDICT_ARP       = 4'd1,
    VERDICT_IPV4      = 4'd2,
    VERDICT_ICMP      = 4'd3,
    VERDICT_SHORT_ETH = 4'd4,
    VERDICT_SHORT_IP  = 4'd5,
    VERDICT_BAD_IPSUM = 4'd6,
    VERDICT_SHORT_ARP = 4'd7,
    VERDICT_SHORT_ICMP = 4'd8,
    VERDICT_BAD_ICMPSUM = 4'd9
  } verdict_e;

  typedef struct packed {
    verdict_e               verdict;
    logic [FrameLenW-1:0]   frame_length;
  } eiv_result_t;

  // ones-complement 16-bit add with end-around carry
  function automatic logic [WordW-1:0] oc_add(input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/eiv_if.sv =====
// byte and result channel interfaces of the frame validator
`default_nettype none

interface eiv_byte_if import eiv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_byte;
  logic             last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface eiv_result_if import eiv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VerdictW-1:0]  verdict;
  logic [FrameLenW-1:0] frame_length;

  modport source (output valid, output verdict, output frame_length, input ready);
  modport sink (input valid, input verdict, input frame_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ethernet_ipv4_icmp_frame_validator.sv =====
// the verdict of a frame passes the input register and then the result register after its last byte transfer
// throughput: one byte per cycle, set by the combinational checksum update between the registers, except that
// a last byte waits while an unaccepted verdict is held; a new frame may follow the previous one without a gap
// reset: asynchronous, clears the frame state and empties both register stages
// no clearing pass; the block accepts bytes in the first cycle after reset
`default_nettype none

`include "ethernet_ipv4_icmp_frame_validator_assert.svh"

module ethernet_ipv4_icmp_frame_validator import eiv_pkg::*; #(
  parameter int MaxFrameBytes = MaxFrameBytesDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  eiv_byte_if.sink       byte_i,
  eiv_result_if.source   result_o
);

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;
  logic             out_valid_q;
  eiv_result_t      out_q;
  eiv_result_t      res;
  logic             adv;

  // non-final bytes never wait on the result side
  assign adv = s1_valid_q && (!s1_last_q || !out_valid_q || result_o.ready);
  assign byte_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      s1_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      s1_byte_q <= byte_i.frame_byte;
      s1_last_q <= byte_i.last_byte;
    end
  end

  eiv_frame_state #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .frame_byte_i(s1_byte_q),
    .last_byte_i (s1_last_q),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_last_q) begin
      out_q <= res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.verdict      = out_q.verdict;
  assign result_o.frame_length = out_q.frame_length;

  `EIV_ASSERT_HOLDS(a_ready_when_empty, clk_i, rst_ni, !s1_valid_q |-> byte_i.ready,
                    "input stalled with empty stage")
  `EIV_ASSERT_HOLDS(a_body_no_stall, clk_i, rst_ni, (s1_valid_q && !s1_last_q) |-> adv,
                    "frame body byte stalled")
  `EIV_ASSERT_HOLDS(a_result_source, clk_i, rst_ni,
                    $rose(out_valid_q) |-> $past(adv && s1_last_q),
                    "result without a final byte")

endmodule

`default_nettype wire

// ===== rtl/core/eiv_frame_state.sv =====
// per-frame parse state, running checksums and verdict logic
`default_nettype none

`include "ethernet_ipv4_icmp_frame_validator_assert.svh"

module eiv_frame_state import eiv_pkg::*; #(
  parameter int MaxFrameBytes = MaxFrameBytesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [ByteW-1:0] frame_byte_i,
  input  wire logic             last_byte_i,
  output eiv_result_t           result_o
);

  localparam int OfsW = $clog2(MaxFrameBytes + 1);
  localparam logic [OfsW-1:0] OfsMax = OfsW'(MaxFrameBytes);

  logic [OfsW-1:0]  offset_q;
  logic             odd_q;
  logic [WordW-1:0] type_q;
  logic [ByteW-1:0] proto_q;
  logic [WordW-1:0] ip_sum_q;
  logic [WordW-1:0] icmp_sum_q;
  logic [ByteW-1:0] pend_q;

  logic [OfsW-1:0]  len;
  logic             in_payload;
  logic             in_ip_hdr;
  logic [WordW-1:0] word;
  logic [WordW-1:0] type_d;
  logic [ByteW-1:0] proto_d;
  logic [WordW-1:0] ip_sum_d;
  logic [WordW-1:0] icmp_sum_d;
  logic [ByteW-1:0] pend_d;
  logic [WordW-1:0] icmp_final;
  logic [OfsW+FrameLenW-1:0] len_wide;
  verdict_e         verdict;

  assign len        = (offset_q == OfsMax) ? offset_q : offset_q + 1'b1;
  assign in_payload = offset_q >= OfsW'(EthHdrBytes);
  assign in_ip_hdr  = offset_q < OfsW'(IpEndBytes);
  assign word       = {pend_q, frame_byte_i};

  always_comb begin
    type_d = type_q;
    proto_d = proto_q;
    if (offset_q == OfsW'(PosTypeHi)) begin
      type_d = {frame_byte_i, type_q[ByteW-1:0]};
    end else if (offset_q == OfsW'(PosTypeLo)) begin
      type_d = {type_q[WordW-1:ByteW], frame_byte_i};
    end else if (offset_q == OfsW'(PosProto)) begin
      proto_d = frame_byte_i;
    end
  end

  assign pend_d     = (in_payload && !odd_q) ? frame_byte_i : pend_q;
  assign ip_sum_d   = (in_payload && odd_q && in_ip_hdr) ? oc_add(ip_sum_q, word) : ip_sum_q;
  assign icmp_sum_d = (in_payload && odd_q && !in_ip_hdr) ? oc_add(icmp_sum_q, word)
                                                          : icmp_sum_q;
  // odd trailing byte padded with a zero low byte
  assign icmp_final = (!odd_q && !in_ip_hdr) ? oc_add(icmp_sum_q, {frame_byte_i, 8'h00})
                                             : icmp_sum_d;

  always_comb begin
    if (len < OfsW'(EthHdrBytes)) begin
      verdict = VERDICT_SHORT_ETH;
    end else if (type_d == TypeIpv4) begin
      if (len < OfsW'(IpEndBytes)) begin
        verdict = VERDICT_SHORT_IP;
      end else if (ip_sum_d != SumOk) begin
        verdict = VERDICT_BAD_IPSUM;
      end else if (proto_d == ProtoIcmp) begin
        if (len < OfsW'(IcmpMinBytes)) begin
          verdict = VERDICT_SHORT_ICMP;
        end else if (icmp_final != SumOk) begin
          verdict = VERDICT_BAD_ICMPSUM;
        end else begin
          verdict = VERDICT_ICMP;
        end
      end else begin
        verdict = VERDICT_IPV4;
      end
    end else if (type_d == TypeArp) begin
      verdict = (len < OfsW'(ArpMinBytes)) ? VERDICT_SHORT_ARP : VERDICT_ARP;
    end else begin
      verdict = VERDICT_OTHER;
    end
  end

  assign len_wide = {{FrameLenW{1'b0}}, len};
  assign result_o.verdict      = verdict;
  assign result_o.frame_length = len_wide[FrameLenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      odd_q      <= 1'b0;
      type_q     <= '0;
      proto_q    <= '0;
      ip_sum_q   <= '0;
      icmp_sum_q <= '0;
      pend_q     <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        offset_q   <= '0;
        odd_q      <= 1'b0;
        type_q     <= '0;
        proto_q    <= '0;
        ip_sum_q   <= '0;
        icmp_sum_q <= '0;
        pend_q     <= '0;
      end else begin
        offset_q   <= len;
        odd_q      <= ~odd_q;
        type_q     <= type_d;
        proto_q    <= proto_d;
        ip_sum_q   <= ip_sum_d;
        icmp_sum_q <= icmp_sum_d;
        pend_q     <= pend_d;
      end
    end
  end

  `EIV_ASSERT_HOLDS(a_offset_bound, clk_i, rst_ni, offset_q <= OfsMax, "byte offset past maximum")
  `EIV_ASSERT_NEXT(a_clear_on_last, clk_i, rst_ni, step_i && last_byte_i,
                   offset_q == '0 && !odd_q && icmp_sum_q == '0, "frame state not cleared")
  `EIV_ASSERT_NEXT(a_phase_toggle, clk_i, rst_ni, step_i && !last_byte_i,
                   odd_q != $past(odd_q), "word phase did not toggle")

endmodule

`default_nettype wire
